// File: sv/mna_pkg.sv
// Package for the Mahalanobis nearest association block: payload types, codes and constants.
`default_nettype none
package mna_pkg;

  localparam int DEFAULT_MAX_FEATURES = 64;
  localparam int DIV_STEPS = 81;
  localparam logic [46:0] INV_LIMIT = 47'h7FFF_FFFF_FFFF;
  localparam logic [47:0] DIST_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_APPEND = 2'd1,
    FN_ASSOC  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] cov_xx;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_yx;
    logic signed [31:0] cov_yy;
  } req_t;

  typedef struct packed {
    logic [5:0]  assoc_index;
    logic [47:0] distance_sq;
    logic        no_feature;
  } rsp_t;

  typedef struct packed {
    logic signed [47:0] ixx;
    logic signed [47:0] ics;
    logic signed [47:0] iyy;
    logic               usable;
  } inv_t;

  typedef struct packed {
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    inv_t               inv;
  } entry_t;

endpackage
`default_nettype wire

// File: sv/mna_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module mna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/mna_inverter.sv
// Covariance inverter: determinant, then, when it is positive, three scaled divisions on one restoring divider.
`default_nettype none
module mna_inverter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] a_in,
  input  wire logic signed [31:0] b_in,
  input  wire logic signed [31:0] c_in,
  input  wire logic signed [31:0] d_in,
  output logic                    done,
  output mna_pkg::inv_t           result
);

  typedef enum logic [1:0] {
    I_IDLE,
    I_DET,
    I_DIV
  } istate_t;

  istate_t            state;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic [63:0]        det;
  logic [32:0]        num [3];
  logic               neg [3];
  logic signed [47:0] res [3];
  logic               usable;
  logic [1:0]         sel;
  logic [6:0]         step;
  logic [80:0]        nsh;
  logic [63:0]        r;
  logic [80:0]        q;

  logic signed [32:0] d_ext;
  logic signed [32:0] a_ext;
  logic signed [33:0] bc;
  logic [64:0]        r_sh;
  logic               qbit;
  logic [64:0]        r_next;
  logic [80:0]        q_next;
  logic [46:0]        sat;
  logic [47:0]        mag48;

  always_comb begin
    d_ext  = {d_in[31], d_in};
    a_ext  = {a_in[31], a_in};
    bc     = {{2{b_in[31]}}, b_in} + {{2{c_in[31]}}, c_in};
    r_sh   = {r, nsh[80]};
    qbit   = (r_sh >= {1'b0, det});
    r_next = qbit ? (r_sh - {1'b0, det}) : r_sh;
    q_next = {q[79:0], qbit};
    sat    = (|q_next[80:47]) ? mna_pkg::INV_LIMIT : q_next[46:0];
    mag48  = {1'b0, sat};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= I_IDLE;
    end else begin
      case (state)
        I_IDLE: begin
          if (start) begin
            p1     <= $signed(a_in) * $signed(d_in);
            p2     <= $signed(b_in) * $signed(c_in);
            num[0] <= d_in[31] ? 33'(-d_ext) : 33'(d_ext);
            neg[0] <= d_in[31];
            num[1] <= bc[33] ? 33'(-bc) : bc[32:0];
            neg[1] <= !bc[33] && (bc != 34'sd0);
            num[2] <= a_in[31] ? 33'(-a_ext) : 33'(a_ext);
            neg[2] <= a_in[31];
            state  <= I_DET;
          end
        end
        I_DET: begin
          if (p1 > p2) begin
            det    <= 64'(p1 - p2);
            usable <= 1'b1;
            sel    <= 2'd0;
            step   <= 7'd0;
            nsh    <= {num[0], 48'b0};
            r      <= 64'd0;
            q      <= 81'd0;
            state  <= I_DIV;
          end else begin
            usable <= 1'b0;
            res[0] <= 48'sd0;
            res[1] <= 48'sd0;
            res[2] <= 48'sd0;
            done   <= 1'b1;
            state  <= I_IDLE;
          end
        end
        I_DIV: begin
          nsh  <= {nsh[79:0], 1'b0};
          r    <= r_next[63:0];
          q    <= q_next;
          step <= step + 7'd1;
          if (step == 7'(mna_pkg::DIV_STEPS - 1)) begin
            res[sel] <= neg[sel] ? -$signed(mag48) : $signed(mag48);
            step     <= 7'd0;
            r        <= 64'd0;
            q        <= 81'd0;
            if (sel == 2'd2) begin
              done  <= 1'b1;
              state <= I_IDLE;
            end else begin
              sel <= sel + 2'd1;
              nsh <= {num[sel + 2'd1], 48'b0};
            end
          end
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  assign result = '{ixx: res[0], ics: res[1], iyy: res[2], usable: usable};

endmodule
`default_nettype wire

// File: sv/mna_dist.sv
// Five-stage pipeline computing the saturated squared Mahalanobis distance of one stored feature.
`default_nettype none
module mna_dist #(
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire mna_pkg::entry_t    entry,
  input  wire logic signed [31:0] meas_x,
  input  wire logic signed [31:0] meas_y,
  output logic                    res_valid,
  output logic                    res_usable,
  output logic [IDX_W-1:0]        res_idx,
  output logic [47:0]             res_dist,
  output logic                    busy
);

  localparam int SW = 115;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [47:0] coef [3];

  // Stage A: differences and coefficient magnitudes.
  logic               a_v, a_u;
  logic [IDX_W-1:0]   a_idx;
  logic [31:0]        a_ax, a_ay;
  logic               a_sx, a_sy;
  logic [47:0]        a_cm [3];
  logic               a_cn [3];
  // Stage B: squares and cross product.
  logic               b_v, b_u;
  logic [IDX_W-1:0]   b_idx;
  logic [63:0]        b_m [3];
  logic [47:0]        b_cm [3];
  logic               b_neg [3];
  // Stage C: partial products.
  logic               c_v, c_u;
  logic [IDX_W-1:0]   c_idx;
  logic [55:0]        c_pp [3][4];
  logic               c_neg [3];
  // Stage D: signed terms.
  logic               d_v, d_u;
  logic [IDX_W-1:0]   d_idx;
  logic signed [SW-1:0] d_t [3];

  logic [111:0]         mag [3];
  logic signed [SW-1:0] sum;

  always_comb begin
    dx      = {meas_x[31], meas_x} - {entry.mean_x[31], entry.mean_x};
    dy      = {meas_y[31], meas_y} - {entry.mean_y[31], entry.mean_y};
    coef[0] = entry.inv.ixx;
    coef[1] = entry.inv.ics;
    coef[2] = entry.inv.iyy;
    for (int t = 0; t < 3; t++) begin
      mag[t] = 112'(c_pp[t][0]) + (112'(c_pp[t][1]) << 24) + (112'(c_pp[t][2]) << 32)
             + (112'(c_pp[t][3]) << 56);
    end
    sum = d_t[0] + d_t[1] + d_t[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      a_v       <= valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      res_valid <= d_v;
    end

    a_u   <= entry.inv.usable;
    a_idx <= idx;
    a_sx  <= dx[32];
    a_sy  <= dy[32];
    a_ax  <= dx[32] ? 32'(-dx) : dx[31:0];
    a_ay  <= dy[32] ? 32'(-dy) : dy[31:0];
    for (int t = 0; t < 3; t++) begin
      a_cm[t] <= coef[t][47] ? 48'(-coef[t]) : coef[t];
      a_cn[t] <= coef[t][47];
    end

    b_u      <= a_u;
    b_idx    <= a_idx;
    b_m[0]   <= a_ax * a_ax;
    b_m[1]   <= a_ax * a_ay;
    b_m[2]   <= a_ay * a_ay;
    b_neg[0] <= a_cn[0];
    b_neg[1] <= a_cn[1] ^ (a_sx ^ a_sy);
    b_neg[2] <= a_cn[2];
    for (int t = 0; t < 3; t++) begin
      b_cm[t] <= a_cm[t];
    end

    c_u   <= b_u;
    c_idx <= b_idx;
    for (int t = 0; t < 3; t++) begin
      c_pp[t][0] <= b_m[t][31:0]  * b_cm[t][23:0];
      c_pp[t][1] <= b_m[t][31:0]  * b_cm[t][47:24];
      c_pp[t][2] <= b_m[t][63:32] * b_cm[t][23:0];
      c_pp[t][3] <= b_m[t][63:32] * b_cm[t][47:24];
      c_neg[t]   <= b_neg[t];
    end

    d_u   <= c_u;
    d_idx <= c_idx;
    for (int t = 0; t < 3; t++) begin
      d_t[t] <= c_neg[t] ? -$signed({3'b0, mag[t]}) : $signed({3'b0, mag[t]});
    end

    res_usable <= d_u;
    res_idx    <= d_idx;
    if (sum[SW-1]) begin
      res_dist <= 48'd0;
    end else if (|sum[SW-2:96]) begin
      res_dist <= mna_pkg::DIST_MAX;
    end else begin
      res_dist <= sum[95:48];
    end
  end

  assign busy = a_v | b_v | c_v | d_v;

endmodule
`default_nettype wire

// File: sv/mahalanobis_nearest_association_top.sv
// Top level of the Mahalanobis nearest association block: control, feature table and argmin.
//
//  Channel | Direction | Signals                   | Payload
//  --------+-----------+---------------------------+------------------------------
//  req     | in        | req_valid, req_ready, req | func, x/y value, covariance
//  rsp     | out       | rsp_valid, rsp_ready, rsp | assoc_index, distance_sq, flag
//
// A clear, an ignored item or an append to a full table is handled in the idle state. An append
// waits for the inverter, whose restoring divider runs three scaled divisions, none when the
// determinant is not positive. A measurement reads one table entry per cycle, then drains the
// five-stage distance pipeline and the argmin; an empty table goes straight to the result.
// Reset clears the control state and the feature count; the table needs no clearing.
// A result waits in the output register; a later measurement's result holds until that transfer ends.
`default_nettype none
module mahalanobis_nearest_association_top #(
  parameter int MAX_FEATURES = mna_pkg::DEFAULT_MAX_FEATURES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire mna_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output mna_pkg::rsp_t      rsp
);

  localparam int IDX_W = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int ENTRY_W = $bits(mna_pkg::entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   iss;
  logic               rq_valid;
  logic [IDX_W-1:0]   rq_idx;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] mean_x;
  logic signed [31:0] mean_y;
  logic               found;
  logic [47:0]        best_dist;
  logic [IDX_W-1:0]   best_idx;

  logic               accept;
  logic               full;
  logic               inv_start;
  logic               inv_done;
  mna_pkg::inv_t      inv_res;
  mna_pkg::entry_t    wentry;
  logic [ENTRY_W-1:0] rdata;
  mna_pkg::entry_t    rentry;
  logic               ram_we;
  logic               ram_re;
  logic               d_valid;
  logic               d_usable;
  logic [IDX_W-1:0]   d_idx;
  logic [47:0]        d_dist;
  logic               d_busy;
  logic [IDX_W+5:0]   idx_wide;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(MAX_FEATURES));
  assign inv_start = accept && (req.func == mna_pkg::FN_APPEND) && !full;
  assign ram_we    = inv_done;
  assign ram_re    = (state == ST_SCAN) && (iss != count);
  assign wentry    = '{mean_x: mean_x, mean_y: mean_y, inv: inv_res};
  assign rentry    = mna_pkg::entry_t'(rdata);
  assign idx_wide  = {6'b0, best_idx};

  mna_inverter u_inv (
    .clk    (clk),
    .rst    (rst),
    .start  (inv_start),
    .a_in   (req.cov_xx),
    .b_in   (req.cov_xy),
    .c_in   (req.cov_yx),
    .d_in   (req.cov_yy),
    .done   (inv_done),
    .result (inv_res)
  );

  // One table entry per feature: means, inverse entries and the usable flag.
  mna_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_FEATURES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata (wentry),
    .re    (ram_re),
    .raddr (iss[IDX_W-1:0]),
    .rdata (rdata)
  );

  mna_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .valid      (rq_valid),
    .idx        (rq_idx),
    .entry      (rentry),
    .meas_x     (meas_x),
    .meas_y     (meas_y),
    .res_valid  (d_valid),
    .res_usable (d_usable),
    .res_idx    (d_idx),
    .res_dist   (d_dist),
    .busy       (d_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      iss       <= '0;
      rq_valid  <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rq_valid <= ram_re;
      rq_idx   <= iss[IDX_W-1:0];
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      // Running minimum; a strict compare keeps the lowest index on ties.
      if (d_valid && d_usable && (!found || d_dist < best_dist)) begin
        found     <= 1'b1;
        best_dist <= d_dist;
        best_idx  <= d_idx;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.func)
              mna_pkg::FN_CLEAR: begin
                count <= '0;
              end
              mna_pkg::FN_APPEND: begin
                if (!full) begin
                  mean_x <= req.x_value;
                  mean_y <= req.y_value;
                  state  <= ST_APPEND;
                end
              end
              mna_pkg::FN_ASSOC: begin
                meas_x <= req.x_value;
                meas_y <= req.y_value;
                found  <= 1'b0;
                iss    <= '0;
                state  <= (count == '0) ? ST_RESULT : ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_APPEND: begin
          if (inv_done) begin
            count <= count + CNT_W'(1);
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            iss <= iss + CNT_W'(1);
          end else if (!rq_valid && !d_busy && !d_valid) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.assoc_index <= found ? idx_wide[5:0] : 6'd0;
            rsp.distance_sq <= found ? best_dist : 48'd0;
            rsp.no_feature  <= !found;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The feature count never runs past the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_FEATURES))
    else $error("feature count exceeds table depth");

  // A result without a usable feature carries index zero and distance zero.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.no_feature |-> rsp.assoc_index == 6'd0 && rsp.distance_sq == 48'd0)
    else $error("empty result carries nonzero fields");

  // The table is written only at the end of an append, never during a scan.
  a_write_in_append: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_APPEND)
    else $error("table written outside an append");

endmodule
`default_nettype wire
